>>> sv/line_tokenizer_with_quotes_comments_top_macros.svh
// ----------------------------------------------------------------------------
// Line tokenizer assertion macros
// Concurrent assertion wrappers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef LINE_TOKENIZER_WITH_QUOTES_COMMENTS_TOP_MACROS_SVH
`define LINE_TOKENIZER_WITH_QUOTES_COMMENTS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked outside reset
`define LTQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ltq assertion failed");
// property checked on every edge, reset included
`define LTQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ltq assertion failed");
`else
`define LTQ_ASSERT(label, clk, rst, prop)
`define LTQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> sv/ltq_pkg.sv
// ----------------------------------------------------------------------------
// Line tokenizer package
// Types, character codes and defaults shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package ltq_pkg;

   // defaults for the top-level parameters
   localparam int MAX_TOKENS_DEF        = 255;
   localparam int LINE_NUMBER_WIDTH_DEF = 24;

   // fixed field widths
   localparam int CHAR_W        = 8;
   localparam int TOKEN_TOTAL_W = 8;
   localparam int LINE_OUT_W    = 24;

   // character codes
   localparam logic [CHAR_W-1:0] CH_HT         = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PRINT_LO   = 8'h21;
   localparam logic [CHAR_W-1:0] CH_PRINT_HI   = 8'h7E;
   localparam logic [CHAR_W-1:0] COMMENT_RESET = 8'd35;
   localparam logic [CHAR_W-1:0] QUOTE_RESET   = 8'd34;

   // register map
   typedef enum logic [0:0] {
      CSR_COMMENT_CHAR = 1'b0,
      CSR_QUOTE_CHAR   = 1'b1
   } ltq_csr_index_type;

   // lexer states
   typedef enum logic [2:0] {
      ST_START   = 3'd0,
      ST_TOKEN   = 3'd1,
      ST_SPACE   = 3'd2,
      ST_STRING  = 3'd3,
      ST_COMMENT = 3'd4
   } ltq_state_type;

   // result status
   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_UNEXPECTED   = 2'd1,
      STATUS_UNTERMINATED = 2'd2,
      STATUS_EARLY_END    = 2'd3
   } ltq_status_type;

   typedef struct packed {
      logic [CHAR_W-1:0] comment_char;
      logic [CHAR_W-1:0] quote_char;
   } ltq_cfg_type;

   typedef struct packed {
      logic [CHAR_W-1:0] data_byte;
      logic              end_of_input;
   } ltq_item_type;

   // held input beat towards the lexer
   typedef struct packed {
      logic         valid;
      ltq_item_type item;
   } ltq_stage_type;

   typedef struct packed {
      logic [CHAR_W-1:0]        out_char;
      logic                     store;
      logic                     token_start;
      logic                     line_end;
      logic                     end_of_file;
      logic [TOKEN_TOTAL_W-1:0] token_total;
      logic [LINE_OUT_W-1:0]    line_number;
      ltq_status_type           status;
   } ltq_result_type;

endpackage

>>> sv/ltq_req_if.sv
// ----------------------------------------------------------------------------
// Line tokenizer input channel
// Valid/ready channel carrying one text byte and the end-of-input flag.
// ----------------------------------------------------------------------------
interface ltq_req_if;
   logic                       valid;
   logic                       ready;
   logic [ltq_pkg::CHAR_W-1:0] data_byte;
   logic                       end_of_input;

   modport source (output valid, data_byte, end_of_input, input ready);
   modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

>>> sv/ltq_rsp_if.sv
// ----------------------------------------------------------------------------
// Line tokenizer result channel
// Valid/ready channel carrying one lexer result per input byte.
// ----------------------------------------------------------------------------
interface ltq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ltq_pkg::CHAR_W-1:0]        out_char;
   logic                              store;
   logic                              token_start;
   logic                              line_end;
   logic                              end_of_file;
   logic [ltq_pkg::TOKEN_TOTAL_W-1:0] token_total;
   logic [ltq_pkg::LINE_OUT_W-1:0]    line_number;
   logic [1:0]                        status;

   modport source (output valid, out_char, store, token_start, line_end, end_of_file,
                   token_total, line_number, status, input ready);
   modport sink   (input valid, out_char, store, token_start, line_end, end_of_file,
                   token_total, line_number, status, output ready);
endinterface

>>> sv/line_tokenizer_with_quotes_comments_top.sv
// ----------------------------------------------------------------------------
// Line tokenizer top level
// Splits a byte stream into lines of tokens with quoted strings and comments.
// ----------------------------------------------------------------------------
// The block takes one text byte per beat and returns exactly one result beat
// for it, sustaining one byte per clock cycle while results are taken; a byte
// passes the input register, then the result register; the lexer state and
// the token and line counters update in the step that takes the byte, which
// sets that rate. While a result waits, one more byte can be taken into the
// input register; after that the input stalls until the result beat leaves.
// Write the comment and quote characters only while no byte is in flight.

module line_tokenizer_with_quotes_comments_top #(
   parameter int MAX_TOKENS        = ltq_pkg::MAX_TOKENS_DEF,
   parameter int LINE_NUMBER_WIDTH = ltq_pkg::LINE_NUMBER_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   ltq_req_if.sink                    req_bus,
   ltq_rsp_if.source                  rsp_bus,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [ltq_pkg::CHAR_W-1:0] csr_wdata
);

   ltq_pkg::ltq_cfg_type   cfg;
   ltq_pkg::ltq_stage_type stage;
   logic                   take;

   // configuration registers
   ltq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register
   ltq_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .stage   (stage)
   );

   // lexer and result register
   ltq_lexer #(
      .MAX_TOKENS        (MAX_TOKENS),
      .LINE_NUMBER_WIDTH (LINE_NUMBER_WIDTH)
   ) u_lexer (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .stage   (stage),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> sv/ltq_csr.sv
// ----------------------------------------------------------------------------
// Line tokenizer configuration registers
// Holds the comment and quote characters, written through a plain port.
// ----------------------------------------------------------------------------
module ltq_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [ltq_pkg::CHAR_W-1:0] csr_wdata,
   output ltq_pkg::ltq_cfg_type       cfg
);

   logic [ltq_pkg::CHAR_W-1:0] comment_ff, comment_in;
   logic [ltq_pkg::CHAR_W-1:0] quote_ff, quote_in;

   // register write decode
   always_comb begin
      comment_in = comment_ff;
      quote_in   = quote_ff;
      if (csr_we) begin
         unique case (ltq_pkg::ltq_csr_index_type'(csr_index))
            ltq_pkg::CSR_COMMENT_CHAR: comment_in = csr_wdata;
            ltq_pkg::CSR_QUOTE_CHAR:   quote_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff <= ltq_pkg::COMMENT_RESET;
         quote_ff   <= ltq_pkg::QUOTE_RESET;
      end else begin
         comment_ff <= comment_in;
         quote_ff   <= quote_in;
      end
   end

   assign cfg.comment_char = comment_ff;
   assign cfg.quote_char   = quote_ff;

endmodule

>>> sv/ltq_in_stage.sv
// ----------------------------------------------------------------------------
// Line tokenizer input register
// Captures one input beat and holds it until the lexer takes it.
// ----------------------------------------------------------------------------
module ltq_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   ltq_req_if.sink                req_bus,
   input  logic                   take,
   output ltq_pkg::ltq_stage_type stage
);

   logic                  valid_ff, valid_in;
   ltq_pkg::ltq_item_type item_ff, item_in;
   logic                  accept;

   // room when empty or when the held beat leaves this cycle
   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff && !take;
      if (accept) begin
         item_in.data_byte    = req_bus.data_byte;
         item_in.end_of_input = req_bus.end_of_input;
         valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

>>> sv/ltq_lexer.sv
// ----------------------------------------------------------------------------
// Line tokenizer lexer
// Five-state lexer, token and line counters, and the result register.
// ----------------------------------------------------------------------------
`include "line_tokenizer_with_quotes_comments_top_macros.svh"

module ltq_lexer #(
   parameter int MAX_TOKENS        = ltq_pkg::MAX_TOKENS_DEF,
   parameter int LINE_NUMBER_WIDTH = ltq_pkg::LINE_NUMBER_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ltq_pkg::ltq_cfg_type   cfg,
   input  ltq_pkg::ltq_stage_type stage,
   output logic                   take,
   ltq_rsp_if.source              rsp_bus
);

   localparam int TW = $clog2(MAX_TOKENS + 1);
   localparam int LW = LINE_NUMBER_WIDTH;

   ltq_pkg::ltq_state_type state_ff, state_in, st;
   logic [TW-1:0]          tokens_ff, tokens_in, tokens_shown;
   logic [LW-1:0]          line_ff, line_in;
   logic                   res_valid_ff, res_valid_in;
   ltq_pkg::ltq_result_type res_ff, res_in;

   logic [ltq_pkg::CHAR_W-1:0] c;
   logic eof, eol, blank, printable, is_comment, is_quote;
   logic store, tstart, lend, eoff, finish, restart, adv;
   ltq_pkg::ltq_status_type status;
   logic [TW+7:0] tokens_ext;
   logic [LW+23:0] line_ext;

   // the lexer steps when a beat is held and the result register has room
   assign take = stage.valid && (!res_valid_ff || rsp_bus.ready);

   // character classes
   assign c          = stage.item.data_byte;
   assign eof        = stage.item.end_of_input;
   assign eol        = (c == ltq_pkg::CH_LF) || (c == ltq_pkg::CH_CR);
   assign blank      = (c == ltq_pkg::CH_SPACE) ||
                       ((c >= ltq_pkg::CH_HT) && (c <= ltq_pkg::CH_CR));
   assign printable  = (c >= ltq_pkg::CH_PRINT_LO) && (c <= ltq_pkg::CH_PRINT_HI);
   assign is_comment = (c == cfg.comment_char);
   assign is_quote   = (c == cfg.quote_char);

   // unused codes act as the start state
   always_comb begin
      unique case (state_ff)
         ltq_pkg::ST_TOKEN, ltq_pkg::ST_SPACE, ltq_pkg::ST_STRING,
         ltq_pkg::ST_COMMENT: st = state_ff;
         default:             st = ltq_pkg::ST_START;
      endcase
   end

   // per-byte flags and status
   always_comb begin
      store   = 1'b0;
      tstart  = 1'b0;
      lend    = 1'b0;
      eoff    = 1'b0;
      finish  = 1'b0;
      restart = 1'b0;
      adv     = 1'b0;
      status  = ltq_pkg::STATUS_OK;
      unique case (st)
         ltq_pkg::ST_STRING: begin
            if (eof) begin
               status = ltq_pkg::STATUS_UNTERMINATED;
               eoff   = 1'b1;
               finish = 1'b1;
            end else if (eol) begin
               status  = ltq_pkg::STATUS_UNTERMINATED;
               restart = 1'b1;
               adv     = 1'b1;
            end else if (!is_quote) begin
               store = 1'b1;
            end
         end
         ltq_pkg::ST_COMMENT: begin
            if (eof) begin
               status = ltq_pkg::STATUS_EARLY_END;
               eoff   = 1'b1;
               finish = 1'b1;
            end else if (eol) begin
               if (tokens_ff != '0) begin
                  lend   = 1'b1;
                  finish = 1'b1;
               end else begin
                  adv = 1'b1;
               end
            end
         end
         default: begin
            if (eof) begin
               if (st != ltq_pkg::ST_START) status = ltq_pkg::STATUS_EARLY_END;
               eoff   = 1'b1;
               finish = 1'b1;
            end else if (st == ltq_pkg::ST_START && c == ltq_pkg::CH_LF) begin
               adv = 1'b1;
            end else if (st != ltq_pkg::ST_START && eol) begin
               lend   = 1'b1;
               finish = 1'b1;
            end else if (blank || is_comment) begin
               // state change only
            end else if (is_quote) begin
               tstart = (st != ltq_pkg::ST_TOKEN);
            end else if (printable) begin
               tstart = (st != ltq_pkg::ST_TOKEN);
               store  = 1'b1;
            end else begin
               status  = ltq_pkg::STATUS_UNEXPECTED;
               restart = 1'b1;
            end
         end
      endcase
   end

   // next lexer state
   always_comb begin
      state_in = st;
      unique case (st)
         ltq_pkg::ST_STRING: begin
            if (!eof && !eol && is_quote) state_in = ltq_pkg::ST_TOKEN;
         end
         ltq_pkg::ST_COMMENT: begin
            if (!eof && eol) state_in = ltq_pkg::ST_START;
         end
         default: begin
            if (eof || eol) begin
               // line ends and input end are handled by finish or restart below
            end else if (blank) begin
               if (st == ltq_pkg::ST_TOKEN) state_in = ltq_pkg::ST_SPACE;
            end else if (is_comment) begin
               state_in = ltq_pkg::ST_COMMENT;
            end else if (is_quote) begin
               state_in = ltq_pkg::ST_STRING;
            end else if (printable) begin
               state_in = ltq_pkg::ST_TOKEN;
            end
         end
      endcase
      if (finish || restart) state_in = ltq_pkg::ST_START;
   end

   // token and line counters, both saturating
   always_comb begin
      tokens_shown = tokens_ff;
      if (tstart && (tokens_ff < TW'(MAX_TOKENS))) tokens_shown = tokens_ff + 1'b1;
      tokens_in = (finish || restart) ? '0 : tokens_shown;
      line_in   = line_ff;
      if ((adv || finish) && (line_ff != {LW{1'b1}})) line_in = line_ff + 1'b1;
   end

   assign tokens_ext = {8'b0, tokens_shown};
   assign line_ext   = {24'b0, line_ff};

   // result register load
   always_comb begin
      res_in             = res_ff;
      res_valid_in       = res_valid_ff && !rsp_bus.ready;
      if (take) begin
         res_valid_in       = 1'b1;
         res_in.out_char    = store ? c : '0;
         res_in.store       = store;
         res_in.token_start = tstart;
         res_in.line_end    = lend;
         res_in.end_of_file = eoff;
         res_in.token_total = (tokens_ext > (TW + 8)'(255)) ? 8'hFF : tokens_ext[7:0];
         res_in.line_number = line_ext[23:0];
         res_in.status      = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltq_pkg::ST_START;
         tokens_ff    <= '0;
         line_ff      <= LW'(1);
         res_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff  <= state_in;
            tokens_ff <= tokens_in;
            line_ff   <= line_in;
         end
         res_valid_ff <= res_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_bus.valid       = res_valid_ff;
   assign rsp_bus.out_char    = res_ff.out_char;
   assign rsp_bus.store       = res_ff.store;
   assign rsp_bus.token_start = res_ff.token_start;
   assign rsp_bus.line_end    = res_ff.line_end;
   assign rsp_bus.end_of_file = res_ff.end_of_file;
   assign rsp_bus.token_total = res_ff.token_total;
   assign rsp_bus.line_number = res_ff.line_number;
   assign rsp_bus.status      = res_ff.status;

   // input end always leaves an empty line in the start state
   `LTQ_ASSERT(a_eof_restarts, clock, reset,
      (take && eof) |=> (state_ff == ltq_pkg::ST_START && tokens_ff == '0))
   // counters only move on a step
   `LTQ_ASSERT(a_line_holds, clock, reset, !take |=> $stable(line_ff))
   // a line end and an input end never share a beat
   `LTQ_ASSERT(a_end_exclusive, clock, reset,
      res_valid_ff |-> !(res_ff.line_end && res_ff.end_of_file))
   // a stored byte never carries an error
   `LTQ_ASSERT(a_store_ok, clock, reset,
      (res_valid_ff && res_ff.store) |-> (res_ff.status == ltq_pkg::STATUS_OK))

endmodule
